FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl of the loudness keep gate
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

FILE: hw/rtl/lkg_pkg.sv
// types and constants of the loudness keep gate
`timescale 1ns / 1ps

package lkg_pkg;

    // sequencer states
    typedef enum logic
    {
        LKG_IDLE,
        LKG_SCAN
    } lkg_state_t;

    // scan control from the sequencer to the serial units
    typedef struct packed
    {
        logic clear;
        logic step;
    } lkg_ctl_t;

    // decision request from the chunk store
    typedef struct packed
    {
        logic go;
        logic flush;
    } lkg_start_t;

    // field widths
    localparam int LEVEL_W    = 16;
    localparam int ROLL_W     = 3;
    localparam int GAP_W      = 4;
    localparam int IDX_OUT_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // item codes
    localparam logic OPC_SAMPLE = 1'b0;
    localparam logic OPC_FLUSH  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYPASS_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_ROLL         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_ROLL        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_GAP        = 3'd4;

    // register reset values
    localparam logic [LEVEL_W-1:0] LEVEL_THRESHOLD_RST = 16'd1024;
    localparam logic               BYPASS_RST          = 1'b0;
    localparam logic [ROLL_W-1:0]  PRE_ROLL_RST        = 3'd2;
    localparam logic [ROLL_W-1:0]  POST_ROLL_RST       = 3'd2;
    localparam logic [GAP_W-1:0]   MERGE_GAP_RST       = 4'd5;

    // tap line around the padded position: seven back, seven ahead
    localparam int                TAP_LEN = 15;
    localparam logic [ROLL_W:0]   TAP_MID = 4'd7;

    // keep line: a filled gap is at most fifteen seconds long
    localparam int                LINE_LEN  = 16;
    localparam int                GAP_CNT_W = 5;
    localparam logic [GAP_CNT_W-1:0] GAP_SAT = 5'd16;

    // step at which the pad unit sees window position zero
    localparam int PAD_LAG = 8;
    // step at which the keep line releases window position zero
    localparam int OUT_LAG = 24;

endpackage

FILE: hw/rtl/loudness_keep_gate.sv
// top level of the loudness keep gate: registers, sequencer, run tracking, result register
`timescale 1ns / 1ps
//
// Input channel (in_valid / in_stall): one transaction per second carries its RMS
// level and force flag (opcode sample), or a flush (opcode flush). Seconds are
// collected into chunks of CHUNK_LEN. A sample that completes a chunk while an
// earlier chunk is pending, or a flush while a chunk is pending, starts a scan
// that decides the pending chunk; other inputs do not start a scan.
// A scan streams the prev/pending/next window one second per cycle, unless the
// receiver stalls, through the pad tap line and the gap-fill keep line; in_stall
// is high for its whole length. The results follow one per cycle, unless the
// receiver stalls, CHUNK_LEN in all, the final one flagged by last.
// Output channel (out_valid / out_stall): a single result register; while the
// receiver stalls, the scan freezes in place and nothing is lost.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once and
// are meant for idle periods. Reset clears the history, the run flag and the
// result valid flag and loads the register defaults.
//
`include "assert_macros.svh"

module loudness_keep_gate #(
    parameter int CHUNK_LEN = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            cfg_write,
    input  logic [lkg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lkg_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [lkg_pkg::LEVEL_W-1:0]     level,
    input  logic                            force_keep,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lkg_pkg::IDX_OUT_W-1:0]   second_index,
    output logic                            keep,
    output logic                            starts_run,
    output logic                            ends_run,
    output logic                            closes_after,
    output logic                            last
);

    localparam int IW        = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
    localparam int SCAN_LEN  = 2 * CHUNK_LEN + lkg_pkg::OUT_LAG;
    localparam int SW        = $clog2(SCAN_LEN);
    localparam int OUT_FIRST = CHUNK_LEN + lkg_pkg::OUT_LAG;
    localparam int PAD_END   = 3 * CHUNK_LEN + lkg_pkg::PAD_LAG;

    // configuration registers
    logic [lkg_pkg::LEVEL_W-1:0] thr_reg;
    logic                        bypass_reg;
    logic [lkg_pkg::ROLL_W-1:0]  pre_reg;
    logic [lkg_pkg::ROLL_W-1:0]  post_reg;
    logic [lkg_pkg::GAP_W-1:0]   gap_reg;

    // sequencer and run state
    lkg_pkg::lkg_state_t state_reg, state_next;
    logic [SW-1:0]       step_reg, step_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic                flush_reg, flush_next;
    logic                run_reg, run_next;

    // result register
    logic                         out_valid_reg, out_valid_next;
    logic [lkg_pkg::IDX_OUT_W-1:0] idx_out_reg;
    logic                         keep_out_reg;
    logic                         starts_out_reg;
    logic                         ends_out_reg;
    logic                         closes_out_reg;
    logic                         last_out_reg;

    logic                in_acc;
    logic                adv;
    logic                emit;
    logic                final_step;
    logic                last_now;
    logic                pad_gated;
    logic [IW+3:0]       idx_ext;
    lkg_pkg::lkg_ctl_t   ctl;
    lkg_pkg::lkg_start_t start;
    logic                scan_bit;
    logic                pad_bit;
    logic                keep_bit;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= lkg_pkg::LEVEL_THRESHOLD_RST;
            bypass_reg <= lkg_pkg::BYPASS_RST;
            pre_reg    <= lkg_pkg::PRE_ROLL_RST;
            post_reg   <= lkg_pkg::POST_ROLL_RST;
            gap_reg    <= lkg_pkg::MERGE_GAP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lkg_pkg::CFG_LEVEL_THRESHOLD:  thr_reg    <= cfg_data[lkg_pkg::LEVEL_W-1:0];
                lkg_pkg::CFG_BYPASS_THRESHOLD: bypass_reg <= cfg_data[0];
                lkg_pkg::CFG_PRE_ROLL:         pre_reg    <= cfg_data[lkg_pkg::ROLL_W-1:0];
                lkg_pkg::CFG_POST_ROLL:        post_reg   <= cfg_data[lkg_pkg::ROLL_W-1:0];
                lkg_pkg::CFG_MERGE_GAP:        gap_reg    <= cfg_data[lkg_pkg::GAP_W-1:0];
                default:                       ;
            endcase
        end
    end

    // handshake and scan timing
    assign in_stall   = (state_reg == lkg_pkg::LKG_SCAN);
    assign in_acc     = in_valid && !in_stall;
    assign adv        = (state_reg == lkg_pkg::LKG_SCAN) && !(out_valid_reg && out_stall);
    assign emit       = adv && (int'(step_reg) >= OUT_FIRST);
    assign final_step = (step_reg == SW'(SCAN_LEN - 1));
    assign last_now   = (idx_reg == IW'(CHUNK_LEN - 1));
    assign pad_gated  = pad_bit && (int'(step_reg) >= lkg_pkg::PAD_LAG)
                        && (int'(step_reg) < PAD_END);
    assign idx_ext    = {4'b0000, idx_reg};

    always_comb
    begin
        ctl.clear = start.go;
        ctl.step  = adv;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        flush_next     = flush_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            lkg_pkg::LKG_IDLE:
            begin
                if (start.go)
                begin
                    state_next = lkg_pkg::LKG_SCAN;
                    step_next  = '0;
                    idx_next   = '0;
                    flush_next = start.flush;
                end
                else if (in_acc && (opcode == lkg_pkg::OPC_FLUSH))
                begin
                    run_next = 1'b0;
                end
            end
            lkg_pkg::LKG_SCAN:
            begin
                if (adv)
                begin
                    step_next = step_reg + SW'(1);
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        run_next       = keep_bit;
                        idx_next       = idx_reg + IW'(1);
                    end
                    if (final_step)
                    begin
                        state_next = lkg_pkg::LKG_IDLE;
                        if (flush_reg)
                        begin
                            run_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = lkg_pkg::LKG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkg_pkg::LKG_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            flush_reg     <= 1'b0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            flush_reg     <= flush_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            idx_out_reg    <= idx_ext[lkg_pkg::IDX_OUT_W-1:0];
            keep_out_reg   <= keep_bit;
            starts_out_reg <= keep_bit && !run_reg;
            ends_out_reg   <= !keep_bit && run_reg;
            closes_out_reg <= flush_reg && last_now && keep_bit;
            last_out_reg   <= last_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign second_index = idx_out_reg;
    assign keep         = keep_out_reg;
    assign starts_run   = starts_out_reg;
    assign ends_run     = ends_out_reg;
    assign closes_after = closes_out_reg;
    assign last         = last_out_reg;

    // chunk store
    lkg_chunks #(
        .CHUNK_LEN (CHUNK_LEN)
    ) u_chunks (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .accept           (in_acc),
        .opcode           (opcode),
        .level            (level),
        .force_keep       (force_keep),
        .level_threshold  (thr_reg),
        .bypass_threshold (bypass_reg),
        .start            (start),
        .scan_bit         (scan_bit)
    );

    // pad unit
    lkg_pad u_pad (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .win_bit   (scan_bit),
        .pre_roll  (pre_reg),
        .post_roll (post_reg),
        .pad_bit   (pad_bit)
    );

    // gap fill
    lkg_fill u_fill (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .pad_bit   (pad_gated),
        .merge_gap (gap_reg),
        .keep_bit  (keep_bit)
    );

    // checks
    `ASSERT_CLK(a_idle_no_emit, (state_reg == lkg_pkg::LKG_IDLE) |-> !emit, "result emitted while idle")
    `ASSERT_CLK(a_last_ends_scan, (emit && last_now) |=> (state_reg == lkg_pkg::LKG_IDLE), "scan runs past last result")
    `ASSERT_CLK(a_flush_drops_run, (adv && final_step && flush_reg) |=> !run_reg, "run open after flush")
    `ASSERT_NEVER(a_run_marks_excl, out_valid && starts_run && ends_run, "run opened and closed at once")

endmodule

FILE: hw/rtl/lkg_chunks.sv
// chunk store: loudness of each second, prev/pending/filling chunks, serial window
`timescale 1ns / 1ps

module lkg_chunks #(
    parameter int CHUNK_LEN = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lkg_pkg::lkg_ctl_t            ctl,
    input  logic                         accept,
    input  logic                         opcode,
    input  logic [lkg_pkg::LEVEL_W-1:0]  level,
    input  logic                         force_keep,
    input  logic [lkg_pkg::LEVEL_W-1:0]  level_threshold,
    input  logic                         bypass_threshold,
    output lkg_pkg::lkg_start_t          start,
    output logic                         scan_bit
);

    localparam int IW  = (CHUNK_LEN > 1) ? $clog2(CHUNK_LEN) : 1;
    localparam int WIN = 3 * CHUNK_LEN;

    logic [CHUNK_LEN-1:0] prev_reg, prev_next;
    logic [CHUNK_LEN-1:0] pend_reg, pend_next;
    logic [CHUNK_LEN-1:0] fill_reg, fill_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IW-1:0]        count_reg, count_next;
    logic                 forced_reg, forced_next;
    logic [WIN-1:0]       scan_reg, scan_next;

    logic                 forced_now;
    logic                 loud;
    logic                 done;
    logic [CHUNK_LEN-1:0] fill_full;

    // loudness of the incoming second
    always_comb
    begin
        forced_now = (count_reg == '0) ? force_keep : forced_reg;
        loud       = bypass_threshold || forced_now || (level >= level_threshold);
        done       = (count_reg == IW'(CHUNK_LEN - 1));
        for (int k = 0; k < CHUNK_LEN; k++)
        begin
            fill_full[k] = (IW'(k) == count_reg) ? loud : fill_reg[k];
        end
    end

    // decision requests
    always_comb
    begin
        start.go    = accept && pend_valid_reg && ((opcode == lkg_pkg::OPC_FLUSH) || done);
        start.flush = accept && pend_valid_reg && (opcode == lkg_pkg::OPC_FLUSH);
    end

    // chunk bookkeeping and window shift register
    always_comb
    begin
        prev_next       = prev_reg;
        pend_next       = pend_reg;
        fill_next       = fill_reg;
        pend_valid_next = pend_valid_reg;
        count_next      = count_reg;
        forced_next     = forced_reg;
        scan_next       = scan_reg;

        if (ctl.step)
        begin
            scan_next = {1'b0, scan_reg[WIN-1:1]};
        end

        if (accept)
        begin
            if (opcode == lkg_pkg::OPC_FLUSH)
            begin
                if (pend_valid_reg)
                begin
                    scan_next = {{CHUNK_LEN{1'b0}}, pend_reg, prev_reg};
                end
                prev_next       = '0;
                pend_next       = '0;
                fill_next       = '0;
                pend_valid_next = 1'b0;
                count_next      = '0;
                forced_next     = 1'b0;
            end
            else if (done)
            begin
                if (pend_valid_reg)
                begin
                    scan_next = {fill_full, pend_reg, prev_reg};
                    prev_next = pend_reg;
                end
                pend_next       = fill_full;
                pend_valid_next = 1'b1;
                fill_next       = '0;
                count_next      = '0;
                forced_next     = 1'b0;
            end
            else
            begin
                fill_next   = fill_full;
                count_next  = count_reg + IW'(1);
                forced_next = forced_now;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            pend_reg       <= '0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            forced_reg     <= 1'b0;
        end
        else
        begin
            prev_reg       <= prev_next;
            pend_reg       <= pend_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            forced_reg     <= forced_next;
        end
    end

    // window copy for the scan
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    assign scan_bit = scan_reg[0];

endmodule

FILE: hw/rtl/lkg_pad.sv
// pad unit: marks a position padded when a loud second lies within the roll range
`timescale 1ns / 1ps

module lkg_pad (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lkg_pkg::lkg_ctl_t            ctl,
    input  logic                         win_bit,
    input  logic [lkg_pkg::ROLL_W-1:0]   pre_roll,
    input  logic [lkg_pkg::ROLL_W-1:0]   post_roll,
    output logic                         pad_bit
);

    logic [lkg_pkg::TAP_LEN-1:0] tap_reg, tap_next;
    logic [lkg_pkg::ROLL_W:0]    lo;
    logic [lkg_pkg::ROLL_W:0]    hi;

    // tap k holds the window bit k steps back; the center tap is the position itself
    always_comb
    begin
        lo      = lkg_pkg::TAP_MID - {1'b0, pre_roll};
        hi      = lkg_pkg::TAP_MID + {1'b0, post_roll};
        pad_bit = 1'b0;
        for (int k = 0; k < lkg_pkg::TAP_LEN; k++)
        begin
            if (tap_reg[k] && ((lkg_pkg::ROLL_W + 1)'(k) >= lo)
                && ((lkg_pkg::ROLL_W + 1)'(k) <= hi))
            begin
                pad_bit = 1'b1;
            end
        end
    end

    // tap line shift
    always_comb
    begin
        tap_next = tap_reg;
        if (ctl.clear)
        begin
            tap_next = '0;
        end
        else if (ctl.step)
        begin
            tap_next = {tap_reg[lkg_pkg::TAP_LEN-2:0], win_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else
        begin
            tap_reg <= tap_next;
        end
    end

endmodule

FILE: hw/rtl/lkg_fill.sv
// gap fill: keep line that fills short quiet gaps between padded seconds
`timescale 1ns / 1ps

module lkg_fill (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lkg_pkg::lkg_ctl_t            ctl,
    input  logic                         pad_bit,
    input  logic [lkg_pkg::GAP_W-1:0]    merge_gap,
    output logic                         keep_bit
);

    logic [lkg_pkg::LINE_LEN-1:0]  line_reg, line_next;
    logic [lkg_pkg::GAP_CNT_W-1:0] gap_reg, gap_next;
    logic                          seen_reg, seen_next;

    logic                          fill;
    logic [lkg_pkg::LINE_LEN-1:0]  thermo;

    // a padded second closes the gap behind it; short gaps with a left end are filled
    always_comb
    begin
        fill = pad_bit && seen_reg && (gap_reg != '0)
               && (gap_reg <= {1'b0, merge_gap});
        thermo[0] = 1'b0;
        for (int k = 1; k < lkg_pkg::LINE_LEN; k++)
        begin
            thermo[k] = (lkg_pkg::GAP_CNT_W'(k) <= gap_reg);
        end
    end

    // next line, gap count and left-end flag
    always_comb
    begin
        line_next = line_reg;
        gap_next  = gap_reg;
        seen_next = seen_reg;
        if (ctl.clear)
        begin
            line_next = '0;
            gap_next  = '0;
            seen_next = 1'b0;
        end
        else if (ctl.step)
        begin
            line_next = {line_reg[lkg_pkg::LINE_LEN-2:0], pad_bit} | (fill ? thermo : '0);
            if (pad_bit)
            begin
                gap_next  = '0;
                seen_next = 1'b1;
            end
            else if (gap_reg != lkg_pkg::GAP_SAT)
            begin
                gap_next = gap_reg + lkg_pkg::GAP_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
            gap_reg  <= '0;
            seen_reg <= 1'b0;
        end
        else
        begin
            line_reg <= line_next;
            gap_reg  <= gap_next;
            seen_reg <= seen_next;
        end
    end

    // the oldest entry can no longer be filled
    assign keep_bit = line_reg[lkg_pkg::LINE_LEN-1];

endmodule

FILE: tb/lkg_keep_checker.sv
// checker of the loudness keep gate: keep-decision predictor and result scoreboard
`timescale 1ns / 1ps

module lkg_keep_checker #(
    parameter int CHUNK_LEN = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [lkg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lkg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            opcode,
    input  logic [lkg_pkg::LEVEL_W-1:0]     level,
    input  logic                            force_keep,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [lkg_pkg::IDX_OUT_W-1:0]   second_index,
    input  logic                            keep,
    input  logic                            starts_run,
    input  logic                            ends_run,
    input  logic                            closes_after,
    input  logic                            last,
    output int                              fail_count,
    output int                              results_owed
);
    import lkg_pkg::*;

    localparam int WIN_LEN = 3 * CHUNK_LEN;

    typedef struct packed
    {
        logic [IDX_OUT_W-1:0] second_index;
        logic                 keep;
        logic                 starts_run;
        logic                 ends_run;
        logic                 closes_after;
        logic                 last;
    } keep_result_t;

    // register copies
    logic [LEVEL_W-1:0]   loud_level;
    logic                 all_loud;
    logic [ROLL_W-1:0]    roll_before;
    logic [ROLL_W-1:0]    roll_after;
    logic [GAP_W-1:0]     gap_fill;

    // chunk history and run tracking
    logic [CHUNK_LEN-1:0] prev_chunk;
    logic [CHUNK_LEN-1:0] held_chunk;
    logic [CHUNK_LEN-1:0] open_chunk;
    logic                 held_valid;
    logic                 open_forced;
    logic                 run_open;
    int                   open_count;

    keep_result_t         decisions_due[$];
    keep_result_t         want;

    // forget every chunk and close the run
    task automatic clear_history();
        prev_chunk  = '0;
        held_chunk  = '0;
        open_chunk  = '0;
        held_valid  = 1'b0;
        open_forced = 1'b0;
        run_open    = 1'b0;
        open_count  = 0;
    endtask

    // decide the held chunk over the prev/held/next window
    task automatic decide_chunk(input logic [CHUNK_LEN-1:0] next_chunk, input logic flushing);
        logic [WIN_LEN-1:0] win;
        logic [WIN_LEN-1:0] pad;
        int                 i;
        int                 j;
        int                 s;
        int                 lo;
        int                 hi;
        int                 l;
        int                 r;
        int                 pos;
        logic               kept;
        keep_result_t       res;
        win = {next_chunk, held_chunk, prev_chunk};
        pad = '0;
        // spread each loud second back by pre-roll and ahead by post-roll
        for (i = 0; i < WIN_LEN; i++)
        begin
            lo = i - int'(roll_after);
            hi = i + int'(roll_before);
            if (lo < 0)
                lo = 0;
            if (hi > WIN_LEN - 1)
                hi = WIN_LEN - 1;
            for (j = lo; j <= hi; j++)
            begin
                if (win[j])
                    pad[i] = 1'b1;
            end
        end
        for (s = 0; s < CHUNK_LEN; s++)
        begin
            pos  = CHUNK_LEN + s;
            kept = pad[pos];
            // fill a short quiet gap with padded seconds inside the window on both sides
            if (!kept)
            begin
                l = pos - 1;
                r = pos + 1;
                while (l >= 0 && !pad[l])
                    l--;
                while (r < WIN_LEN && !pad[r])
                    r++;
                kept = (l >= 0) && (r < WIN_LEN) && ((r - l - 1) <= int'(gap_fill));
            end
            res = '0;
            res.second_index = IDX_OUT_W'(s);
            res.keep = kept;
            // run open and close marks
            if (kept)
            begin
                if (!run_open)
                begin
                    res.starts_run = 1'b1;
                    run_open = 1'b1;
                end
            end
            else if (run_open)
            begin
                res.ends_run = 1'b1;
                run_open = 1'b0;
            end
            res.closes_after = flushing && (s == CHUNK_LEN - 1) && run_open;
            res.last = (s == CHUNK_LEN - 1);
            decisions_due.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input logic [IDX_OUT_W-1:0] want_v,
                               input logic [IDX_OUT_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loud_level  = LEVEL_THRESHOLD_RST;
            all_loud    = BYPASS_RST;
            roll_before = PRE_ROLL_RST;
            roll_after  = POST_ROLL_RST;
            gap_fill    = MERGE_GAP_RST;
            clear_history();
            decisions_due.delete();
            results_owed = 0;
        end
        else
        begin
            // register writes, masked to each register's width
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_LEVEL_THRESHOLD:  loud_level  = cfg_data[LEVEL_W-1:0];
                    CFG_BYPASS_THRESHOLD: all_loud    = cfg_data[0];
                    CFG_PRE_ROLL:         roll_before = cfg_data[ROLL_W-1:0];
                    CFG_POST_ROLL:        roll_after  = cfg_data[ROLL_W-1:0];
                    CFG_MERGE_GAP:        gap_fill    = cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            // input transaction
            if (in_valid && !in_stall)
            begin
                if (opcode == OPC_FLUSH)
                begin
                    if (held_valid)
                        decide_chunk('0, 1'b1);
                    clear_history();
                end
                else
                begin
                    if (open_count == 0)
                        open_forced = force_keep;
                    open_chunk[open_count] = all_loud || open_forced || (level >= loud_level);
                    open_count++;
                    // chunk complete: decide the held one, then shift the history
                    if (open_count == CHUNK_LEN)
                    begin
                        if (held_valid)
                        begin
                            decide_chunk(open_chunk, 1'b0);
                            prev_chunk = held_chunk;
                        end
                        held_chunk  = open_chunk;
                        held_valid  = 1'b1;
                        open_chunk  = '0;
                        open_count  = 0;
                        open_forced = 1'b0;
                    end
                end
            end
            // output transaction
            if (out_valid && !out_stall)
            begin
                if (decisions_due.size() == 0)
                begin
                    $display("%0t: result with none expected, expected nothing, actual index %0d keep %0d",
                             $time, second_index, keep);
                    fail_count++;
                end
                else
                begin
                    want = decisions_due.pop_front();
                    check_field("second_index", want.second_index, second_index);
                    check_field("keep", want.keep, keep);
                    check_field("starts_run", want.starts_run, starts_run);
                    check_field("ends_run", want.ends_run, ends_run);
                    check_field("closes_after", want.closes_after, closes_after);
                    check_field("last", want.last, last);
                end
            end
            results_owed = decisions_due.size();
        end
    end

endmodule

FILE: tb/tb.sv
// testbench top of the loudness keep gate: stimulus, receiver pacing, watchdog and verdict
`timescale 1ns / 1ps

module tb;
    import lkg_pkg::*;

    localparam int CHUNK_LEN    = 16;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 23;
    localparam int MAX_WAIT     = 13;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 64;
    localparam int IDLE_LIMIT   = 3000;

    // indexes past the register list, which the block ignores
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  opcode = OPC_SAMPLE;
    logic [LEVEL_W-1:0]    level = '0;
    logic                  force_keep = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [IDX_OUT_W-1:0]  second_index;
    logic                  keep;
    logic                  starts_run;
    logic                  ends_run;
    logic                  closes_after;
    logic                  last;

    int                    fail_count;
    int                    results_owed;
    int                    in_wait_max = MAX_WAIT;
    int                    out_wait_max = MAX_WAIT;
    bit                    hold_req = 1'b0;
    logic [LEVEL_W-1:0]    level_thr = LEVEL_THRESHOLD_RST;
    int                    fill_pos = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    loudness_keep_gate #(.CHUNK_LEN(CHUNK_LEN)) dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .level(level), .force_keep(force_keep),
        .out_valid(out_valid), .out_stall(out_stall),
        .second_index(second_index), .keep(keep), .starts_run(starts_run),
        .ends_run(ends_run), .closes_after(closes_after), .last(last)
    );

    lkg_keep_checker #(.CHUNK_LEN(CHUNK_LEN)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .level(level), .force_keep(force_keep),
        .out_valid(out_valid), .out_stall(out_stall),
        .second_index(second_index), .keep(keep), .starts_run(starts_run),
        .ends_run(ends_run), .closes_after(closes_after), .last(last),
        .fail_count(fail_count), .results_owed(results_owed)
    );

    // one register write, strobe high for a single cycle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // offer one transaction after a random gap, hold it until taken
    task automatic send_item(input logic op, input logic [LEVEL_W-1:0] lvl, input logic frc);
        int gap;
        gap = $urandom_range(0, in_wait_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        level      <= lvl;
        force_keep <= frc;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop offering and wait until every decision has come out and the scan is over
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // levels clustered on the threshold and the extremes
    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0, 1, 2: return '0;
            3:       return '1;
            4:       return level_thr;
            5:       return level_thr - 1'b1;
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    // receiver: a random hold-off before each result, one long one on request
    initial
    begin
        int stall_len;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                stall_len = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall_len = $urandom_range(0, out_wait_max);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("loudness_keep_gate verification failed");
        $finish;
    end

    // stimulus
    initial
    begin
        int                    n;
        int                    ph;
        logic [LEVEL_W-1:0]    lvl;
        logic                  frc;
        logic [CFG_DATA_W-1:0] thr_word;
        logic [CFG_DATA_W-1:0] byp_word;
        logic [CFG_DATA_W-1:0] pre_word;
        logic [CFG_DATA_W-1:0] post_word;
        logic [CFG_DATA_W-1:0] gap_word;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // defaults and new roll/gap values, some with junk in the upper bits, plus unused indexes
        write_reg(CFG_LEVEL_THRESHOLD, LEVEL_THRESHOLD_RST);
        write_reg(CFG_BYPASS_THRESHOLD, 16'h0002);
        write_reg(CFG_PRE_ROLL, 16'hFFFA);
        write_reg(CFG_POST_ROLL, 16'h0003);
        write_reg(CFG_MERGE_GAP, 16'hFFF4);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);

        // flush with nothing held, ignored fields set
        send_item(OPC_FLUSH, 16'hFFFF, 1'b1);
        // first chunk: threshold edges and full scale; late force flags are ignored
        for (n = 0; n < CHUNK_LEN; n++)
        begin
            case (n)
                2:       lvl = level_thr - 1'b1;
                3:       lvl = level_thr;
                10:      lvl = 16'hFFFF;
                default: lvl = '0;
            endcase
            send_item(OPC_SAMPLE, lvl, n == 1 || n == 12);
        end
        // partial chunk forced at its first second, dropped by the flush
        for (n = 0; n < 7; n++)
            send_item(OPC_SAMPLE, '0, n == 0);
        send_item(OPC_FLUSH, '0, 1'b0);
        fill_pos = 0;

        // random phases, each under its own register setting
        for (ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    thr_word = '0;
                    byp_word = '0;
                    pre_word = '0;
                    post_word = '0;
                    gap_word = '0;
                end
                1:
                begin
                    thr_word = '1;
                    byp_word = '0;
                    pre_word = 16'd7;
                    post_word = 16'd7;
                    gap_word = 16'd15;
                end
                2:
                begin
                    thr_word = CFG_DATA_W'($urandom_range(64, 65000));
                    byp_word = 16'h0001;
                    pre_word = CFG_DATA_W'($urandom_range(0, 7));
                    post_word = CFG_DATA_W'($urandom_range(0, 7));
                    gap_word = CFG_DATA_W'($urandom_range(0, 15));
                end
                default:
                begin
                    thr_word = CFG_DATA_W'($urandom_range(64, 65000));
                    byp_word = CFG_DATA_W'($urandom) & 16'hFFFE;
                    pre_word = CFG_DATA_W'($urandom);
                    post_word = CFG_DATA_W'($urandom);
                    gap_word = CFG_DATA_W'($urandom);
                end
            endcase
            level_thr = thr_word;
            write_reg(CFG_LEVEL_THRESHOLD, thr_word);
            write_reg(CFG_BYPASS_THRESHOLD, byp_word);
            write_reg(CFG_PRE_ROLL, pre_word);
            write_reg(CFG_POST_ROLL, post_word);
            write_reg(CFG_MERGE_GAP, gap_word);

            in_wait_max = (ph == 1 || ph == 3) ? 0 : MAX_WAIT;
            out_wait_max = (ph == 1 || ph == 2) ? 0 : MAX_WAIT;
            // one phase where the receiver backs up the whole block
            if (ph == 4)
                hold_req = 1'b1;

            // mostly whole chunks, with an occasional flush in the middle
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    send_item(OPC_FLUSH, LEVEL_W'($urandom), 1'($urandom_range(0, 1)));
                    fill_pos = 0;
                end
                else
                begin
                    if (fill_pos == 0)
                        frc = ($urandom_range(0, 4) == 0);
                    else
                        frc = 1'($urandom_range(0, 1));
                    send_item(OPC_SAMPLE, pick_level(), frc);
                    fill_pos = (fill_pos + 1) % CHUNK_LEN;
                end
            end
        end

        // drain, then verdict
        wait_drained();
        if (fail_count == 0 && results_owed == 0)
            $display("loudness_keep_gate verification clean");
        else
            $display("loudness_keep_gate verification failed");
        $finish;
    end

endmodule
